/* hdl/decimal_string_to_integer_core_macros.svh */
// ----------------------------------------------------------------------------
// Decimal string converter assertion macros
// Shared concurrent assertion forms for the converter's checks.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_INTEGER_CORE_MACROS_SVH
`define DECIMAL_STRING_TO_INTEGER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("decimal string converter check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("decimal string converter check failed");

`endif

/* hdl/dsi_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal string converter package
// Character codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

    localparam int CH_W            = 8;
    localparam int DIGIT_W         = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MINUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LZ    = 1'd1;

    // One character word held in the input register.
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] ch;
    } t_char_word;

    // Mode bits from the configuration registers.
    typedef struct packed {
        logic allow_minus;
        logic allow_lz;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/dsi_in_reg.sv */
// ----------------------------------------------------------------------------
// Decimal string converter input register
// Holds one character word until the parse stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_in_reg import dsi_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [CH_W-1:0] i_ch,
    input  wire logic            i_advance,
    output t_char_word           o_word
);

    logic            r_valid;
    logic [CH_W-1:0] r_ch;
    logic            w_load;

    // A word can enter when the register is empty or is draining this cycle.
    assign o_in_ready = !r_valid || i_advance;
    assign w_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ch <= i_ch;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.ch    = r_ch;

endmodule

`default_nettype wire

/* hdl/dsi_parse.sv */
// ----------------------------------------------------------------------------
// Decimal string converter parse stage
// Per-string state machine and accumulator; forms the result at a NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_parse import dsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_char_word             i_word,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_out_free,
    output logic                        o_advance,
    output logic                        o_res_valid,
    output logic                        o_res_ok,
    output logic [VALUE_WIDTH-1:0]      o_res_value
);

    localparam int ACC_W = VALUE_WIDTH - 1;
    localparam int SUM_W = VALUE_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZEROS,
        PH_ONEZERO,
        PH_DIGITS
    } t_phase;

    t_phase           r_phase,   n_phase;
    logic             r_neg,     n_neg;
    logic             r_fz,      n_fz;
    logic             r_failed,  n_failed;
    logic [ACC_W-1:0] r_acc,     n_acc;

    logic               w_is_nul;
    logic               w_is_digit;
    logic               w_is_zero;
    logic [CH_W-1:0]    w_ch_off;
    logic [DIGIT_W-1:0] w_digit;
    logic [SUM_W-1:0]   w_acc_ext;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_lim;
    logic               w_ovf;
    logic [VALUE_WIDTH-1:0] w_mag;

    assign w_is_nul   = (i_word.ch == CH_NUL);
    assign w_is_digit = (i_word.ch >= CH_ZERO) && (i_word.ch <= CH_NINE);
    assign w_is_zero  = (i_word.ch == CH_ZERO);
    assign w_ch_off   = i_word.ch - CH_ZERO;
    assign w_digit    = w_ch_off[DIGIT_W-1:0];

    // Times ten as two shifts and an add; overflow when above the largest positive.
    assign w_acc_ext = SUM_W'(r_acc);
    assign w_sum     = (w_acc_ext << 3) + (w_acc_ext << 1) + SUM_W'(w_digit);
    assign w_lim     = SUM_W'({ACC_W{1'b1}});
    assign w_ovf     = (w_sum > w_lim);

    // A NUL needs room in the result register; other characters never stall.
    assign o_advance = i_word.valid && (!w_is_nul || i_out_free);

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_fz     = r_fz;
        n_failed = r_failed;
        n_acc    = r_acc;
        if (w_is_nul) begin
            n_phase  = PH_START;
            n_neg    = 1'b0;
            n_fz     = 1'b0;
            n_failed = 1'b0;
            n_acc    = '0;
        end else if (!r_failed) begin
            unique case (r_phase)
                PH_START, PH_SIGN: begin
                    if (r_phase == PH_START && i_word.ch == CH_MINUS && i_cfg.allow_minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else begin
                        if (r_phase == PH_START) begin
                            n_fz = w_is_zero;
                        end
                        if (w_is_zero) begin
                            n_phase = i_cfg.allow_lz ? PH_ZEROS : PH_ONEZERO;
                        end else if (w_is_digit) begin
                            n_acc   = ACC_W'(w_digit);
                            n_phase = PH_DIGITS;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
                PH_ZEROS: begin
                    if (w_is_zero) begin
                        n_phase = PH_ZEROS;
                    end else if (w_is_digit) begin
                        n_acc   = ACC_W'(w_digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_ONEZERO: begin
                    n_failed = 1'b1;
                end
                PH_DIGITS: begin
                    if (w_is_digit && !w_ovf) begin
                        n_acc = w_sum[ACC_W-1:0];
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_neg    <= 1'b0;
            r_fz     <= 1'b0;
            r_failed <= 1'b0;
            r_acc    <= '0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_fz     <= n_fz;
            r_failed <= n_failed;
            r_acc    <= n_acc;
        end
    end

    // Result of the string that the NUL closes.
    assign w_mag = {1'b0, r_acc};

    always_comb begin
        o_res_ok    = 1'b0;
        o_res_value = '0;
        if (!r_failed) begin
            case (r_phase)
                PH_ZEROS: begin
                    o_res_ok = r_fz;
                end
                PH_ONEZERO: begin
                    o_res_ok = 1'b1;
                end
                PH_DIGITS: begin
                    o_res_ok    = 1'b1;
                    o_res_value = r_neg ? (~w_mag + 1'b1) : w_mag;
                end
                default: begin
                    o_res_ok = 1'b0;
                end
            endcase
        end
    end

    assign o_res_valid = o_advance && w_is_nul;

endmodule

`default_nettype wire

/* hdl/dsi_out_reg.sv */
// ----------------------------------------------------------------------------
// Decimal string converter result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsi_out_reg import dsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_ok,
    input  wire logic [VALUE_WIDTH-1:0] i_res_value,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_ok,
    output logic [VALUE_WIDTH-1:0]      o_value
);

    logic                   r_valid;
    logic                   r_ok;
    logic [VALUE_WIDTH-1:0] r_value;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_ok    <= i_res_ok;
            r_value <= i_res_value;
        end
    end

    assign o_out_valid = r_valid;
    assign o_ok        = r_ok;
    assign o_value     = r_value;

endmodule

`default_nettype wire

/* hdl/decimal_string_to_integer_core.sv */
// A NUL word passes from the input register through the parse stage to the
// result register. The block takes one character word per cycle, but a NUL
// waits while the result register is full and not being taken; the parse
// state machine and its times-ten accumulator step once per character.
// Reset (synchronous, active low) clears both mode bits, the per-string state
// and the valid flags of the input and result registers.
// ----------------------------------------------------------------------------
// Decimal string to integer converter
// Streams ASCII characters, one per word, and returns a success flag and a
// signed value for every NUL-terminated string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_string_to_integer_core_macros.svh"

module decimal_string_to_integer_core import dsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic                   i_cfg_data,
    // Character input channel.
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [CH_W-1:0]        i_ch,
    // Result output channel.
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_ok,
    output logic signed [VALUE_WIDTH-1:0] o_value
);

    // Mode registers, written in any cycle; the user must write them only when
    // no string is in flight (unchecked), so each character sees stable modes.
    logic r_allow_minus;
    logic r_allow_lz;
    t_cfg w_cfg;

    // Pipeline interconnect: the input register feeds the parse stage,
    // which hands a finished result to the result register.
    t_char_word             w_word;
    logic                   w_advance;
    logic                   w_out_free;
    logic                   w_res_valid;
    logic                   w_res_ok;
    logic [VALUE_WIDTH-1:0] w_res_value;
    logic [VALUE_WIDTH-1:0] w_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_minus <= 1'b0;
            r_allow_lz    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALLOW_MINUS: r_allow_minus <= i_cfg_data;
                CFG_ALLOW_LZ:    r_allow_lz    <= i_cfg_data;
                default:         r_allow_lz    <= r_allow_lz;
            endcase
        end
    end

    assign w_cfg.allow_minus = r_allow_minus;
    assign w_cfg.allow_lz    = r_allow_lz;

    // Input register: takes a new word whenever it is empty or its current
    // word moves on in the same cycle, so words can arrive back to back.
    dsi_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ch       (i_ch),
        .i_advance  (w_advance),
        .o_word     (w_word)
    );

    // Parse stage: one state update per character. Only a NUL waits, and
    // only when the result register is still full and not being taken.
    dsi_parse #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .i_cfg       (w_cfg),
        .i_out_free  (w_out_free),
        .o_advance   (w_advance),
        .o_res_valid (w_res_valid),
        .o_res_ok    (w_res_ok),
        .o_res_value (w_res_value)
    );

    // Result register: decouples the consumer from the parse stage; a waiting
    // result blocks only the NUL of the next string, not its other characters.
    dsi_out_reg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res_ok    (w_res_ok),
        .i_res_value (w_res_value),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_value     (w_value)
    );

    assign o_value = w_value;

    // A failed string always reports zero.
    `DSI_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_ok, w_value == '0)
    // The most negative code is never produced, since magnitudes are capped.
    `DSI_ASSERT_SAME(a_no_min, i_clk, i_rst_n, o_out_valid && o_ok,
        w_value != {1'b1, {(VALUE_WIDTH-1){1'b0}}})
    // A NUL leaving the parse stage shows up as a result in the next cycle.
    `DSI_ASSERT_NEXT(a_nul_result, i_clk, i_rst_n, w_res_valid, o_out_valid)
    // Input back-pressure only comes from a held word in the input register.
    `DSI_ASSERT_SAME(a_stall_src, i_clk, i_rst_n, !o_in_ready,
        w_word.valid && (w_word.ch == CH_NUL) && !w_out_free)

endmodule

`default_nettype wire

/* tb/decimal_string_to_integer_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal string converter checker
// Watches the mode, character and result channels, keeps its own parser to
// predict one result per NUL, and compares each result word in order.
// ----------------------------------------------------------------------------

module decimal_string_to_integer_core_checker import dsi_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                   i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [CH_W-1:0]        i_ch,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic                   i_ok,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef enum logic [2:0] {
        PARSE_START,
        PARSE_SIGN,
        PARSE_ZEROS,
        PARSE_ONE_ZERO,
        PARSE_DIGITS
    } t_parse_phase;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_WIDTH-1:0] value;
    } t_conv_result;

    localparam logic [63:0] MAX_MAGNITUDE = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    t_parse_phase parse_phase;
    logic         negative;
    logic         began_with_zero;
    logic         parse_error;
    logic [63:0]  magnitude;
    logic         mode_minus;
    logic         mode_lz;
    t_conv_result conversions_q[$];
    int           fails = 0;

    function automatic bit is_decimal(input logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_string();
        parse_phase     = PARSE_START;
        negative        = 1'b0;
        began_with_zero = 1'b0;
        parse_error     = 1'b0;
        magnitude       = '0;
    endtask

    // Overflow is caught before the multiply, so the magnitude never wraps.
    task automatic append_digit(input logic [CH_W-1:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (magnitude > (MAX_MAGNITUDE - d) / 64'd10) begin
            parse_error = 1'b1;
        end else begin
            magnitude = magnitude * 64'd10 + d;
        end
    endtask

    task automatic start_number(input logic [CH_W-1:0] c);
        if (c == CH_ZERO) begin
            parse_phase = mode_lz ? PARSE_ZEROS : PARSE_ONE_ZERO;
        end else if (is_decimal(c)) begin
            magnitude = '0;
            append_digit(c);
            parse_phase = PARSE_DIGITS;
        end else begin
            parse_error = 1'b1;
        end
    endtask

    task automatic take_char(input logic [CH_W-1:0] c);
        if (!parse_error) begin
            case (parse_phase)
                PARSE_START: begin
                    if (c == CH_MINUS && mode_minus) begin
                        negative    = 1'b1;
                        parse_phase = PARSE_SIGN;
                    end else begin
                        began_with_zero = (c == CH_ZERO);
                        start_number(c);
                    end
                end
                PARSE_SIGN: begin
                    start_number(c);
                end
                PARSE_ZEROS: begin
                    if (is_decimal(c) && c != CH_ZERO) begin
                        magnitude = '0;
                        append_digit(c);
                        parse_phase = PARSE_DIGITS;
                    end else if (c != CH_ZERO) begin
                        parse_error = 1'b1;
                    end
                end
                PARSE_ONE_ZERO: begin
                    parse_error = 1'b1;
                end
                default: begin
                    if (is_decimal(c)) begin
                        append_digit(c);
                    end else begin
                        parse_error = 1'b1;
                    end
                end
            endcase
        end
    endtask

    task automatic finish_string();
        t_conv_result r;
        r = '0;
        if (!parse_error) begin
            case (parse_phase)
                PARSE_ZEROS:    r.ok = began_with_zero;
                PARSE_ONE_ZERO: r.ok = 1'b1;
                PARSE_DIGITS: begin
                    r.ok    = 1'b1;
                    r.value = VALUE_WIDTH'(negative ? (64'd0 - magnitude) : magnitude);
                end
                default: r.ok = 1'b0;
            endcase
        end
        conversions_q.push_back(r);
        clear_string();
    endtask

    task automatic report_failure(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] converter check: %s", $time, msg);
        end
    endtask

    task automatic compare_result();
        t_conv_result r;
        if (conversions_q.size() == 0) begin
            report_failure($sformatf("result word with no string pending (ok %0b value %0d)",
                                     i_ok, $signed(i_value)));
        end else begin
            r = conversions_q.pop_front();
            if (i_ok !== r.ok) begin
                report_failure($sformatf("ok expected %0b, got %0b", r.ok, i_ok));
            end
            if (i_value !== r.value) begin
                report_failure($sformatf("value expected %0d, got %0d",
                                         $signed(r.value), $signed(i_value)));
            end
        end
    endtask

    // All channel inputs are driven by nonblocking assignments, so the values
    // read here are the ones present just before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string();
            mode_minus = 1'b0;
            mode_lz    = 1'b0;
            conversions_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ALLOW_MINUS) begin
                    mode_minus = i_cfg_data;
                end else if (i_cfg_index == CFG_ALLOW_LZ) begin
                    mode_lz = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                compare_result();
            end
            if (i_in_valid && i_in_ready) begin
                if (i_ch == CH_NUL) begin
                    finish_string();
                end else begin
                    take_char(i_ch);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= conversions_q.size();
    end

endmodule

/* tb/decimal_string_to_integer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal string converter testbench
// Streams directed and random character strings through the converter under
// all mode settings, with random stalls on both channels, and lets the
// checker beside the block judge every result word.
// ----------------------------------------------------------------------------

module decimal_string_to_integer_core_test import dsi_pkg::*; ;

    localparam int VALUE_W = VALUE_WIDTH_DEF;

    // About this many characters go in; the last part runs without stalls.
    localparam int ITEM_TARGET = 1000;
    localparam int CALM_START  = 850;

    // The result of a NUL is registered in the result register, so this
    // margin is enough for the block to settle before a mode write.
    localparam int SETTLE_CYCLES = 8;

    // Slowest correct run is far below this: every character waiting out the
    // longest gap plus every result waiting out the longest stall.
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CH_W-1:0] CH_LETTER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_TOP_BIT  = 8'h80;
    localparam logic [CH_W-1:0] CH_ALL_ONES = 8'hFF;

    localparam logic [63:0] MAX_MAGNITUDE = (64'd1 << (VALUE_W - 1)) - 64'd1;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_ALLOW_MINUS;
    logic                 cfg_data    = 1'b0;
    logic                 ch_valid    = 1'b0;
    logic                 ch_ready;
    logic [CH_W-1:0]      ch_data     = CH_NUL;
    logic                 res_valid;
    logic                 res_ready   = 1'b0;
    logic                 res_ok;
    logic [VALUE_W-1:0]   res_value;

    int          fail_count;
    int          pending;
    int          sent_count = 0;
    int          idle_odds  = 4;
    int          res_stall  = 0;
    int          cycle_count = 0;
    logic [CH_W-1:0] text_q[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    decimal_string_to_integer_core #(
        .VALUE_WIDTH (VALUE_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (ch_valid),
        .o_in_ready  (ch_ready),
        .i_ch        (ch_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_ok        (res_ok),
        .o_value     (res_value)
    );

    decimal_string_to_integer_core_checker #(
        .VALUE_WIDTH (VALUE_W)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (ch_valid),
        .i_in_ready   (ch_ready),
        .i_ch         (ch_data),
        .i_out_valid  (res_valid),
        .i_out_ready  (res_ready),
        .i_ok         (res_ok),
        .i_value      (res_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side stalls in bursts. A burst begins with odds of one in
    // idle_odds; zero odds keep ready high throughout.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            res_stall <= 0;
        end else if (res_stall != 0) begin
            res_ready <= 1'b0;
            res_stall <= res_stall - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            res_ready <= 1'b0;
            res_stall <= $urandom_range(0, 12);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // A hung handshake must not hang the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Presents one character word and holds it until the block takes it.
    // Valid is lowered only when a gap is inserted, so back-to-back words
    // never see valid dropped and raised within one step.
    task automatic send_char(input logic [CH_W-1:0] c);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            ch_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        ch_valid <= 1'b1;
        ch_data  <= c;
        do @(posedge clk); while (!ch_ready);
        sent_count++;
    endtask

    task automatic send_text();
        foreach (text_q[k]) begin
            send_char(text_q[k]);
        end
        send_char(CH_NUL);
        text_q.delete();
    endtask

    task automatic send_literal(input string s);
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
        send_text();
    endtask

    // Mode writes happen only with no string in flight: the character channel
    // is parked, every result has been taken, and the block has settled.
    task automatic wait_drained();
        ch_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modes(input logic minus_on, input logic lz_on);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ALLOW_MINUS;
        cfg_data  <= minus_on;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_ALLOW_LZ;
        cfg_data  <= lz_on;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Magnitudes lean toward the overflow boundary and toward zero; the rest
    // are random numbers of 1 to 9 digits, or sometimes of 10 to 12 digits.
    function automatic logic [63:0] pick_magnitude();
        logic [63:0] m;
        m = '0;
        case ($urandom_range(0, 9))
            0: m = MAX_MAGNITUDE;
            1: m = MAX_MAGNITUDE + 64'd1;
            2: m = MAX_MAGNITUDE - 64'($urandom_range(0, 9));
            3: m = MAX_MAGNITUDE + 64'($urandom_range(1, 99));
            4: m = '0;
            5: begin
                repeat ($urandom_range(10, 12)) m = m * 64'd10 + 64'($urandom_range(0, 9));
            end
            default: begin
                repeat ($urandom_range(1, 9)) m = m * 64'd10 + 64'($urandom_range(0, 9));
            end
        endcase
        return m;
    endfunction

    task automatic push_digits(input logic [63:0] m);
        logic [CH_W-1:0] rev[$];
        if (m == 0) begin
            text_q.push_back(CH_ZERO);
        end else begin
            while (m != 0) begin
                rev.push_front(CH_ZERO + CH_W'(m % 64'd10));
                m = m / 64'd10;
            end
            foreach (rev[k]) text_q.push_back(rev[k]);
        end
    endtask

    // Most strings are well formed numbers with an optional sign and leading
    // zeros; some get one stray character at a random place, and the rest are
    // random bytes, empty strings among them.
    task automatic build_string();
        int          kind;
        logic [63:0] m;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(0, 6)) text_q.push_back(CH_W'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                text_q.push_back(CH_MINUS);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
            end
            m = pick_magnitude();
            // A zero magnitude after a sign or zeros is sometimes left out,
            // which yields a lone minus or a run of zeros only.
            if (!(m == 0 && text_q.size() != 0 && $urandom_range(0, 1) == 1)) begin
                push_digits(m);
            end
            if (kind < 35) begin
                text_q.insert($urandom_range(0, text_q.size()),
                              ($urandom_range(0, 3) == 0) ? CH_MINUS
                                                          : CH_W'($urandom_range(1, 255)));
            end
        end
    endtask

    initial begin
        int phase_no;
        int strings_left;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both modes off after reset: a lone zero is legal, a sign is just a
        // bad character, a zero followed by more digits fails, and bytes with
        // the top bit set are rejected.
        send_literal("0");
        send_literal("");
        send_literal("-5");
        send_literal("05");
        text_q.push_back(CH_LETTER_A);
        text_q.push_back(CH_TOP_BIT);
        send_text();
        send_literal("7");
        text_q.push_back(CH_ALL_ONES);
        send_text();

        // Both modes on: a lone minus and a minus with only zeros fail, while
        // zeros ahead of a digit are fine.
        wait_drained();
        write_modes(1'b1, 1'b1);
        send_literal("-");
        send_literal("-00");
        send_literal("007");

        // Random phases. The first four walk every mode combination, then the
        // modes are drawn at random. Each phase has its own idling odds, zero
        // among them, and the calm tail turns idling off on both sides.
        phase_no = 0;
        while (sent_count < ITEM_TARGET) begin
            wait_drained();
            case (phase_no)
                0:       write_modes(1'b0, 1'b1);
                1:       write_modes(1'b1, 1'b0);
                2:       write_modes(1'b0, 1'b0);
                3:       write_modes(1'b1, 1'b1);
                default: write_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            case ($urandom_range(0, 3))
                0:       idle_odds = 0;
                1:       idle_odds = 2;
                2:       idle_odds = 5;
                default: idle_odds = 9;
            endcase
            strings_left = $urandom_range(10, 20);
            while (strings_left != 0 && sent_count < ITEM_TARGET) begin
                if (sent_count >= CALM_START) begin
                    idle_odds = 0;
                end
                build_string();
                send_text();
                strings_left--;
            end
            phase_no++;
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/dsi_pkg.sv
hdl/dsi_in_reg.sv
hdl/dsi_parse.sv
hdl/dsi_out_reg.sv
hdl/decimal_string_to_integer_core.sv
tb/decimal_string_to_integer_core_checker.sv
tb/decimal_string_to_integer_core_test.sv
